[hw/rtl/kruskal_spanning_tree_union_find_core_macros.svh]
// Assertion macros shared by the checker of the spanning tree core.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef KRUSKAL_SPANNING_TREE_UNION_FIND_CORE_MACROS_SVH
`define KRUSKAL_SPANNING_TREE_UNION_FIND_CORE_MACROS_SVH

// same-cycle implication
`define KSTUF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kstuf same-cycle check failed");

// next-cycle implication
`define KSTUF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kstuf next-cycle check failed");

`endif

[hw/rtl/kstuf_pkg.sv]
// Types, constants and the microprogram of the spanning tree core.
// No dependencies.
package kstuf_pkg;

  localparam int RANK_BITS  = 2;
  localparam int TOTAL_BITS = 20;
  localparam int COUNT_BITS = 3;
  localparam int NCNT_BITS  = 4;
  localparam int WIN_BITS   = 16;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 3'd7;
  localparam logic [RANK_BITS-1:0]  RANK_MAX  = 2'd3;
  localparam logic [NCNT_BITS-1:0]  NODE_COUNT_RESET = 4'd8;

  typedef struct packed {
    logic [WIN_BITS-1:0] edge_weight;
    logic [2:0]          node_a;
    logic [2:0]          node_b;
    logic                first_edge;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [TOTAL_BITS-1:0] total_weight;
    logic [COUNT_BITS-1:0] edges_taken;
    logic                  spanning;
  } out_item_t;

  // step counter and program addresses
  typedef logic [3:0] step_t;
  localparam step_t ST_IDLE    = 4'd0;
  localparam step_t ST_FA_RD   = 4'd1;
  localparam step_t ST_FA_WALK = 4'd2;
  localparam step_t ST_CMP_A   = 4'd3;
  localparam step_t ST_FB_WALK = 4'd4;
  localparam step_t ST_CMP_B   = 4'd5;
  localparam step_t ST_TEST    = 4'd6;
  localparam step_t ST_LINK    = 4'd7;
  localparam step_t ST_BUMP    = 4'd8;
  localparam step_t ST_FIN     = 4'd9;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ROOT,     // fetched entry points at itself
    C_AT_RA,    // fetched node is root of a
    C_AT_RB,
    C_DIFF,     // roots differ
    C_RANK_EQ
  } cond_t;

  typedef enum logic [1:0] {
    RD_HOLD,
    RD_A,
    RD_B,
    RD_PARENT
  } rd_src_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_COMP_A,   // point fetched node at root of a
    W_COMP_B,
    W_LINK,     // hang one root under the other
    W_BUMP      // raise rank of root b
  } wr_op_t;

  typedef enum logic [1:0] {
    LAT_NONE,
    LAT_RA,
    LAT_RB,
    LAT_OK
  } lat_t;

  // hit: cond met -> next step (or idle on fin); miss -> jmp
  typedef struct packed {
    cond_t   cond;
    step_t   jmp;
    rd_src_t rd_hit;
    rd_src_t rd_miss;
    wr_op_t  wr_hit;
    wr_op_t  wr_miss;
    lat_t    lat;
    logic    fin;
  } uword_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t u;
    u = '{C_ALWAYS, ST_IDLE, RD_HOLD, RD_HOLD, W_NONE, W_NONE, LAT_NONE, 1'b0};
    case (pc)
      ST_FA_RD:   u = '{C_ALWAYS, ST_IDLE, RD_A, RD_HOLD, W_NONE, W_NONE,
                        LAT_NONE, 1'b0};
      ST_FA_WALK: u = '{C_ROOT, ST_FA_WALK, RD_A, RD_PARENT, W_NONE, W_NONE,
                        LAT_RA, 1'b0};
      ST_CMP_A:   u = '{C_AT_RA, ST_CMP_A, RD_B, RD_PARENT, W_NONE, W_COMP_A,
                        LAT_NONE, 1'b0};
      ST_FB_WALK: u = '{C_ROOT, ST_FB_WALK, RD_B, RD_PARENT, W_NONE, W_NONE,
                        LAT_RB, 1'b0};
      ST_CMP_B:   u = '{C_AT_RB, ST_CMP_B, RD_HOLD, RD_PARENT, W_NONE, W_COMP_B,
                        LAT_NONE, 1'b0};
      ST_TEST:    u = '{C_DIFF, ST_FIN, RD_HOLD, RD_HOLD, W_NONE, W_NONE,
                        LAT_OK, 1'b0};
      ST_LINK:    u = '{C_RANK_EQ, ST_FIN, RD_HOLD, RD_HOLD, W_LINK, W_LINK,
                        LAT_NONE, 1'b0};
      ST_BUMP:    u = '{C_ALWAYS, ST_IDLE, RD_HOLD, RD_HOLD, W_BUMP, W_NONE,
                        LAT_NONE, 1'b0};
      ST_FIN:     u = '{C_ALWAYS, ST_IDLE, RD_HOLD, RD_HOLD, W_NONE, W_NONE,
                        LAT_NONE, 1'b1};
      default:    u = '{C_ALWAYS, ST_IDLE, RD_HOLD, RD_HOLD, W_NONE, W_NONE,
                        LAT_NONE, 1'b0};
    endcase
    return u;
  endfunction

endpackage

[hw/rtl/kstuf_ram.sv]
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module kstuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/kruskal_spanning_tree_union_find_core.sv]
// Top level of the spanning tree accumulator: union-find forest in a RAM,
// driven by a microprogram from kstuf_pkg. Uses kstuf_ram.
//
// Usage:
//   Input: put an edge on in_item and raise start; the beat is taken at a
//   clock edge with start high and busy low. busy stays high while the edge
//   is worked on. first_edge set clears the forest and the totals first.
//   Output: one result per edge on out_item, marked by out_valid for exactly
//   one cycle. The receiver cannot stall; the result is simply shown once.
//   Config: cfg_we with cfg_wdata writes node_count; only while idle.
// Timing:
//   Each root search walks the parent chain one node per cycle through the
//   single read port of the forest RAM, then walks it again to compress it.
//   Compression and union writes share the single write port. out_valid
//   rises at the edge where busy falls, and a new edge can be taken in that
//   same cycle. Trees stay at most 3 deep.
// Reset:
//   Synchronous, active low. Per-node valid bits clear at once, so every
//   node reads as its own root with rank zero; totals zero, node_count 8.
module kruskal_spanning_tree_union_find_core
  import kstuf_pkg::*;
#(
  parameter int MAX_NODES   = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [NCNT_BITS-1:0] cfg_wdata
);

  localparam int PW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = PW + RANK_BITS;

  // node id taken modulo the forest size; id is at most 7
  function automatic logic [PW-1:0] id_wrap(input logic [2:0] id);
    logic [2:0] v;
    v = id;
    for (int k = 0; k < 3; k++) begin
      if (int'(v) >= MAX_NODES) begin
        v = v - 3'(MAX_NODES);
      end
    end
    return PW'(v);
  endfunction

  step_t                 pc_r, pc_nxt;
  logic [PW-1:0]         a_r, b_r, ra_r, rb_r, addr_q_r;
  logic [RANK_BITS-1:0]  rka_r, rkb_r;
  logic                  ok_r, vq_r;
  logic [MAX_NODES-1:0]  valid_r;
  logic [WIN_BITS-1:0]   w_r, w_mask;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [NCNT_BITS-1:0]  node_count_r;
  out_item_t             out_r;
  logic                  out_valid_r;

  uword_t                uw;
  logic                  hit, accept;
  rd_src_t               rd_sel;
  wr_op_t                wr_sel;
  logic [PW-1:0]         raddr, waddr, rd_parent;
  logic [EW-1:0]         rdata, wdata, eff;
  logic [RANK_BITS-1:0]  rd_rank;
  logic                  we;
  logic [TOTAL_BITS:0]   sum;
  logic                  span_nxt;

  assign accept = start && (pc_r == ST_IDLE);
  assign uw     = ucode(pc_r);

  // never-written entries read as their own root
  assign eff       = vq_r ? rdata : {{RANK_BITS{1'b0}}, addr_q_r};
  assign rd_parent = eff[PW-1:0];
  assign rd_rank   = eff[EW-1:PW];

  always_comb begin
    for (int i = 0; i < WIN_BITS; i++) begin
      w_mask[i] = (i < WEIGHT_BITS) ? in_item.edge_weight[i] : 1'b0;
    end
  end

  always_comb begin
    case (uw.cond)
      C_ALWAYS:  hit = 1'b1;
      C_ROOT:    hit = (rd_parent == addr_q_r);
      C_AT_RA:   hit = (addr_q_r == ra_r);
      C_AT_RB:   hit = (addr_q_r == rb_r);
      C_DIFF:    hit = (ra_r != rb_r);
      C_RANK_EQ: hit = (rka_r == rkb_r);
      default:   hit = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    if (pc_r == ST_IDLE) begin
      pc_nxt = accept ? ST_FA_RD : ST_IDLE;
    end else if (hit) begin
      pc_nxt = uw.fin ? ST_IDLE : step_t'(pc_r + 4'd1);
    end else begin
      pc_nxt = uw.jmp;
    end
  end

  // datapath controls from the control word
  always_comb begin
    rd_sel = hit ? uw.rd_hit : uw.rd_miss;
    wr_sel = hit ? uw.wr_hit : uw.wr_miss;
    case (rd_sel)
      RD_A:      raddr = a_r;
      RD_B:      raddr = b_r;
      RD_PARENT: raddr = rd_parent;
      default:   raddr = addr_q_r;
    endcase
    we    = 1'b1;
    waddr = addr_q_r;
    wdata = {rd_rank, ra_r};
    case (wr_sel)
      W_COMP_A: begin
        waddr = addr_q_r;
        wdata = {rd_rank, ra_r};
      end
      W_COMP_B: begin
        waddr = addr_q_r;
        wdata = {rd_rank, rb_r};
      end
      W_LINK: begin
        if (rka_r > rkb_r) begin
          waddr = rb_r;
          wdata = {rkb_r, ra_r};
        end else begin
          waddr = ra_r;
          wdata = {rka_r, rb_r};
        end
      end
      W_BUMP: begin
        waddr = rb_r;
        wdata = {(rkb_r == RANK_MAX) ? rkb_r : RANK_BITS'(rkb_r + 2'd1), rb_r};
      end
      default: we = 1'b0;
    endcase
  end

  // totals at the end of the program
  always_comb begin
    sum       = {1'b0, total_r} + (TOTAL_BITS + 1)'(w_r);
    total_nxt = total_r;
    count_nxt = count_r;
    if (ok_r) begin
      total_nxt = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      count_nxt = (count_r == COUNT_MAX) ? count_r : COUNT_BITS'(count_r + 3'd1);
    end
    span_nxt = ({1'b0, count_nxt} == NCNT_BITS'(node_count_r - 4'd1));
  end

  kstuf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NODES)
  ) u_forest (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_IDLE;
      valid_r      <= '0;
      total_r      <= '0;
      count_r      <= '0;
      ok_r         <= 1'b0;
      node_count_r <= NODE_COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= (pc_r != ST_IDLE) && uw.fin;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (accept) begin
        ok_r <= 1'b0;
        if (in_item.first_edge) begin
          valid_r <= '0;
          total_r <= '0;
          count_r <= '0;
        end
      end else if (hit && uw.lat == LAT_OK) begin
        ok_r <= 1'b1;
      end
      if ((pc_r != ST_IDLE) && uw.fin) begin
        total_r <= total_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vq_r     <= valid_r[raddr];
    addr_q_r <= raddr;
    if (accept) begin
      a_r <= id_wrap(in_item.node_a);
      b_r <= id_wrap(in_item.node_b);
      w_r <= w_mask;
    end
    if (hit && uw.lat == LAT_RA) begin
      ra_r  <= addr_q_r;
      rka_r <= rd_rank;
    end
    if (hit && uw.lat == LAT_RB) begin
      rb_r  <= addr_q_r;
      rkb_r <= rd_rank;
    end
    if ((pc_r != ST_IDLE) && uw.fin) begin
      out_r.accepted     <= ok_r;
      out_r.total_weight <= total_nxt;
      out_r.edges_taken  <= count_nxt;
      out_r.spanning     <= span_nxt;
    end
  end

  assign busy      = (pc_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[hw/rtl/kstuf_checker.sv]
// Port-level checker for the spanning tree core, bound to the top level.
// Depends on kstuf_pkg and the assertion macro header.
`include "kruskal_spanning_tree_union_find_core_macros.svh"

module kstuf_checker
  import kstuf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // the result beat is a single-cycle strobe
  `KSTUF_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  // a taken edge always occupies the block
  `KSTUF_ASSERT_NXT(a_take_busy, start && !busy, busy)
  // the result shows only once the edge is done
  `KSTUF_ASSERT_IMP(a_out_idle, out_valid, !busy)
  // finishing an edge always produces its result
  `KSTUF_ASSERT_IMP(a_done_out, $fell(busy), out_valid)
  // an accepted edge has been counted
  `KSTUF_ASSERT_IMP(a_acc_count, out_valid && out_item.accepted,
                    out_item.edges_taken != 3'd0)

endmodule

bind kruskal_spanning_tree_union_find_core kstuf_checker u_kstuf_checker (.*);

[verif/kruskal_mst_checker.sv]
// Checker for the spanning tree core: watches the edge, result and config
// ports, keeps its own union-find forest and compares every result beat.
// Depends on kstuf_pkg.
module kruskal_mst_checker
  import kstuf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [NCNT_BITS-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);

  logic [2:0]            parent_of [8];
  logic [RANK_BITS-1:0]  rank_of [8];
  logic [TOTAL_BITS-1:0] weight_sum;
  logic [COUNT_BITS-1:0] edge_tally;
  logic [NCNT_BITS-1:0]  nodes_to_join;
  out_item_t             results_due [$];
  out_item_t             want;

  function automatic void clear_forest();
    for (int i = 0; i < 8; i++) begin
      parent_of[i] = 3'(i);
      rank_of[i]   = '0;
    end
    weight_sum = '0;
    edge_tally = '0;
  endfunction

  // walk to the root, then point every node on the path straight at it
  function automatic logic [2:0] find_root(input logic [2:0] v);
    logic [2:0] r;
    logic [2:0] cur;
    logic [2:0] nxt;
    int         s;
    r = v;
    for (s = 0; s < 8 && parent_of[r] != r; s++)
      r = parent_of[r];
    cur = v;
    for (s = 0; s < 8 && cur != r; s++) begin
      nxt = parent_of[cur];
      parent_of[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  function automatic out_item_t merge_edge(input in_item_t e);
    logic [2:0]            ra;
    logic [2:0]            rb;
    logic [TOTAL_BITS:0]   sum;
    logic [NCNT_BITS-1:0]  need;
    out_item_t             res;
    if (e.first_edge)
      clear_forest();
    ra = find_root(e.node_a);
    rb = find_root(e.node_b);
    res.accepted = (ra != rb);
    if (ra != rb) begin
      if (rank_of[ra] == rank_of[rb]) begin
        if (rank_of[rb] < RANK_MAX)
          rank_of[rb] = rank_of[rb] + 1'b1;
        parent_of[ra] = rb;
      end else if (rank_of[ra] > rank_of[rb]) begin
        parent_of[rb] = ra;
      end else begin
        parent_of[ra] = rb;
      end
      sum = {1'b0, weight_sum} + (TOTAL_BITS + 1)'(e.edge_weight);
      weight_sum = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      if (edge_tally < COUNT_MAX)
        edge_tally = edge_tally + 1'b1;
    end
    // node_count of zero wraps here and never matches
    need = nodes_to_join - 1'b1;
    res.total_weight = weight_sum;
    res.edges_taken  = edge_tally;
    res.spanning     = ({1'b0, edge_tally} == need);
    return res;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // result beat is matched before a same-edge input beat is queued
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_forest();
      nodes_to_join = NODE_COUNT_RESET;
      results_due.delete();
    end else begin
      if (out_valid) begin
        if (results_due.size() == 0) begin
          $error("result beat with no edge outstanding");
          fail_count++;
        end else begin
          want = results_due.pop_front();
          checked++;
          check_field("accepted", 32'(want.accepted), 32'(out_item.accepted));
          check_field("total_weight", 32'(want.total_weight),
                      32'(out_item.total_weight));
          check_field("edges_taken", 32'(want.edges_taken),
                      32'(out_item.edges_taken));
          check_field("spanning", 32'(want.spanning), 32'(out_item.spanning));
        end
      end
      if (start && !busy)
        results_due = {results_due, merge_edge(in_item)};
      if (cfg_we)
        nodes_to_join = cfg_wdata;
    end
    pending = results_due.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the spanning tree core: clock, reset, edge stimulus
// and node_count writes; checking lives in kruskal_mst_checker.
// Depends on kstuf_pkg, the core and the checker.
module tb_top
  import kstuf_pkg::*;
();

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [NCNT_BITS-1:0] cfg_wdata;
  int                   fail_count;
  int                   pending;
  int                   checked;
  int                   edges_sent;
  int                   settings_run;

  kruskal_spanning_tree_union_find_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kruskal_mst_checker u_check (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(12 * 400000);
    $display("** kruskal_spanning_tree_union_find_core: FAILED **");
    $finish;
  end

  // drop start and wait for every outstanding result beat
  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    @(negedge clk);
    while ((pending != 0 || busy) && n < 5000) begin
      @(negedge clk);
      n++;
    end
  endtask

  task automatic write_nodes(input logic [NCNT_BITS-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
    settings_run++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_edge(input in_item_t e, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= e;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    edges_sent++;
    @(negedge clk);
  endtask

  task automatic edge_beat(input logic [WIN_BITS-1:0] w, input logic [2:0] a,
                           input logic [2:0] b, input logic f);
    send_edge('{edge_weight: w, node_a: a, node_b: b, first_edge: f},
              int'($urandom_range(0, 5)));
  endtask

  // mostly sorted edge lists opened by first_edge, with some noise mixed in
  task automatic run_edge_lists(input int quota, input logic [NCNT_BITS-1:0] nc);
    int             done;
    int             len;
    int             span;
    bit             burst;
    logic [WIN_BITS-1:0] w;
    logic [WIN_BITS:0]   nw;
    in_item_t       e;
    done = 0;
    span = (nc >= 1 && nc <= 8) ? int'(nc) : 8;
    while (done < quota) begin
      len   = int'($urandom_range(3, 12));
      burst = ($urandom_range(0, 3) == 0);
      w     = WIN_BITS'($urandom_range(0, 50000));
      for (int j = 0; j < len; j++) begin
        if (j == 0)
          e.first_edge = ($urandom_range(0, 7) != 0);
        else
          e.first_edge = ($urandom_range(0, 24) == 0);
        if ($urandom_range(0, 7) == 0) begin
          e.node_a = 3'($urandom);
          e.node_b = 3'($urandom);
        end else begin
          e.node_a = 3'($urandom_range(0, span - 1));
          e.node_b = 3'($urandom_range(0, span - 1));
        end
        if ($urandom_range(0, 9) == 0) begin
          w = WIN_BITS'($urandom);
        end else begin
          nw = {1'b0, w} + (WIN_BITS + 1)'($urandom_range(0, 3000));
          w  = nw[WIN_BITS] ? '1 : nw[WIN_BITS-1:0];
        end
        e.edge_weight = w;
        send_edge(e, burst ? 0 : int'($urandom_range(0, 5)));
        done++;
      end
      if ($urandom_range(0, 9) == 0)
        drain();
    end
  endtask

  initial begin
    logic [NCNT_BITS-1:0] nc;
    start        = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    edges_sent   = 0;
    settings_run = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // hand-built forest: equal, higher and lower rank unions up to a full tree
    write_nodes(4'd8);
    edge_beat(16'd0, 3'd0, 3'd1, 1'b1);
    edge_beat(16'd0, 3'd3, 3'd3, 1'b0);      // self loop
    edge_beat(16'd1, 3'd1, 3'd0, 1'b0);      // already joined
    edge_beat(16'd2, 3'd2, 3'd3, 1'b0);
    edge_beat(16'd3, 3'd0, 3'd2, 1'b0);
    edge_beat(16'd10, 3'd4, 3'd3, 1'b0);
    edge_beat(16'd20, 3'd1, 3'd5, 1'b0);
    edge_beat(16'd30, 3'd6, 3'd7, 1'b0);
    edge_beat(16'd40000, 3'd7, 3'd2, 1'b0);  // tree now spans
    edge_beat(16'hFFFF, 3'd0, 3'd7, 1'b0);
    edge_beat(16'hFFFF, 3'd7, 3'd0, 1'b1);
    edge_beat(16'd0, 3'd0, 3'd0, 1'b1);
    edge_beat(16'd5, 3'd1, 3'd6, 1'b0);
    // a single node spans with no edges at all
    write_nodes(4'd1);
    edge_beat(16'd7, 3'd5, 3'd5, 1'b1);
    edge_beat(16'd9, 3'd4, 3'd5, 1'b0);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       nc = 4'd0;
        1:       nc = 4'd15;
        2:       nc = 4'd8;
        3:       nc = 4'd2;
        4:       nc = NCNT_BITS'($urandom_range(9, 14));
        default: nc = NCNT_BITS'($urandom_range(1, 8));
      endcase
      write_nodes(nc);
      run_edge_lists(40, nc);
    end

    drain();
    repeat (10) @(negedge clk);
    if (pending != 0)
      $error("%0d result beats never arrived", pending);
    $display("Sent %0d edges under %0d node_count settings, %0d results checked",
             edges_sent, settings_run, checked);
    $display("  (node_count 0, 1, 8, 15 and random values; sorted and noisy lists)");
    if (fail_count == 0 && pending == 0) begin
      $display("** kruskal_spanning_tree_union_find_core: PASSED **");
    end else begin
      $display("** kruskal_spanning_tree_union_find_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/kstuf_pkg.sv
hw/rtl/kstuf_ram.sv
hw/rtl/kruskal_spanning_tree_union_find_core.sv
hw/rtl/kstuf_checker.sv
verif/kruskal_mst_checker.sv
verif/tb_top.sv
